// ----- rtl/hftd_pkg.sv -----
// Shared types, constants and helpers for the hexadecimal float text parser.
// Used by hftd_step and by the top level hex_float_text_to_double.
`default_nettype none

package hftd_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OUT_BITS    = 64 + 2 + OFFSET_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    localparam logic [63:0] NAN_BITS = 64'h7ff8000000000000;
    localparam logic [63:0] INF_BITS = 64'h7ff0000000000000;
    localparam logic [63:0] SIGN_BIT = 64'h8000000000000000;

    localparam logic signed [20:0] ADJ_LIMIT  = 21'sd524287;
    localparam logic [19:0]        DEC_LIMIT  = 20'd100000;
    localparam logic signed [22:0] EXP_BIAS   = 23'sd1023;
    localparam logic signed [22:0] EXP_MAX    = 23'sd2047;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_FORMAT    = 2'd3;

    typedef enum logic [3:0] {
        PH_WS       = 4'd0,
        PH_NAN      = 4'd1,
        PH_SIGNED   = 4'd2,
        PH_INF      = 4'd3,
        PH_ZERO     = 4'd4,
        PH_FIRSTHEX = 4'd5,
        PH_INT      = 4'd6,
        PH_FRAC     = 4'd7,
        PH_EXPSIGN  = 4'd8,
        PH_EXPFIRST = 4'd9,
        PH_EXPDIG   = 4'd10,
        PH_DONE     = 4'd11
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [1:0]              word_match_index;
        logic                    negative;
        logic                    exponent_negative;
        logic [63:0]             fraction_bits;
        logic                    leading_found;
        logic signed [7:0]       bit_position;
        logic signed [19:0]      exponent_adjust;
        logic [19:0]             decimal_exponent;
        logic [OFFSET_BITS-1:0]  position;
        logic                    finished;
        logic [63:0]             held_value;
        logic [1:0]              held_status;
    } parse_state_t;

    function automatic parse_state_t state_clear();
        parse_state_t s;
        s = '0;
        s.phase = PH_WS;
        s.bit_position = 8'sd60;
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hftd_step.sv -----
// Next-state logic of the parser for one text character.
// Depends on hftd_pkg for the parser state type and constants.
`default_nettype none

module hftd_step
    import hftd_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   ch,
    input  logic         strict_end,
    output parse_state_t nxt
);

    logic [7:0]        lc;
    logic              is_space;
    logic              is_sign;
    logic              is_minus;
    logic              is_dec;
    logic              is_hex;
    logic [3:0]        hval;
    logic [7:0]        want;
    logic [OFFSET_BITS-1:0] word_start;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] wmi_ext;
    logic [63:0]       sign_mask;
    logic signed [22:0] exp_sum;
    logic [19:0]       dec_times_ten;
    phase_t            ph;

    function automatic logic signed [19:0] adj_add(input logic signed [19:0] a,
                                                   input logic signed [3:0] delta);
        logic signed [20:0] v;
        v = $signed({a[19], a}) + $signed({{17{delta[3]}}, delta});
        if (v > ADJ_LIMIT) begin
            v = ADJ_LIMIT;
        end
        if (v < -ADJ_LIMIT) begin
            v = -ADJ_LIMIT;
        end
        return v[19:0];
    endfunction

    function automatic parse_state_t finish(input parse_state_t s, input logic [63:0] v,
                                            input logic [1:0] st,
                                            input logic [OFFSET_BITS-1:0] stop);
        parse_state_t r;
        r = s;
        r.held_value = v;
        r.held_status = st;
        r.position = stop;
        r.finished = 1'b1;
        r.phase = PH_DONE;
        return r;
    endfunction

    // The first nonzero digit: its top one bit is the implicit leading one,
    // the bits below it open the fraction.
    function automatic parse_state_t place_leading(input parse_state_t s, input logic [3:0] d,
                                                   input logic in_frac);
        parse_state_t r;
        logic [1:0]   nbits;
        logic signed [3:0] delta;
        r = s;
        if (d[3]) begin
            r.fraction_bits = {d[2:0], 61'b0};
            nbits = 2'd3;
        end else if (d[2]) begin
            r.fraction_bits = {d[1:0], 62'b0};
            nbits = 2'd2;
        end else if (d[1]) begin
            r.fraction_bits = {d[0], 63'b0};
            nbits = 2'd1;
        end else begin
            nbits = 2'd0;
        end
        r.bit_position = s.bit_position - $signed({6'b0, nbits});
        delta = in_frac ? $signed({2'b0, nbits}) - 4'sd4 : $signed({2'b0, nbits});
        r.exponent_adjust = adj_add(s.exponent_adjust, delta);
        r.leading_found = 1'b1;
        return r;
    endfunction

    function automatic parse_state_t append_digit(input parse_state_t s, input logic [3:0] d);
        parse_state_t      r;
        logic signed [7:0] neg_bp;
        logic signed [7:0] bp;
        r = s;
        neg_bp = -s.bit_position;
        if (!s.bit_position[7]) begin
            r.fraction_bits = s.fraction_bits | ({60'b0, d} << s.bit_position[5:0]);
        end else if (s.bit_position > -8'sd4) begin
            r.fraction_bits = s.fraction_bits | ({60'b0, d} >> neg_bp[1:0]);
        end
        bp = s.bit_position - 8'sd4;
        r.bit_position = (bp < -8'sd8) ? -8'sd8 : bp;
        return r;
    endfunction

    always_comb begin
        lc       = (ch inside {["A":"Z"]}) ? ch + 8'd32 : ch;
        is_space = ch inside {[8'd9:8'd13], " "};
        is_minus = (ch == "-");
        is_sign  = (ch == "+") || is_minus;
        is_dec   = ch inside {["0":"9"]};
        is_hex   = is_dec || (lc inside {["a":"f"]});
        hval     = is_dec ? 4'(ch - "0") : 4'(lc - "a" + 8'd10);
        pos_inc  = (cur.position == POS_MAX) ? cur.position : cur.position + 1'b1;
        wmi_ext  = OFFSET_BITS'(cur.word_match_index);
        word_start = (cur.position >= wmi_ext) ? cur.position - wmi_ext : '0;
        sign_mask = cur.negative ? SIGN_BIT : 64'd0;
        dec_times_ten = (cur.decimal_exponent << 3) + (cur.decimal_exponent << 1)
                        + {16'b0, hval};
        exp_sum = $signed({3'b0, cur.decimal_exponent});
        if (cur.exponent_negative) begin
            exp_sum = -exp_sum;
        end
        exp_sum = exp_sum + EXP_BIAS + $signed({{3{cur.exponent_adjust[19]}},
                                                cur.exponent_adjust});
        if (cur.phase == PH_NAN) begin
            want = (cur.word_match_index == 2'd1) ? "a" : "n";
        end else begin
            want = (cur.word_match_index == 2'd1) ? "n" : "f";
        end

        nxt = cur;
        ph  = cur.phase;

        if (ph == PH_WS && (is_space || lc == "n" || is_sign)) begin
            nxt.position = pos_inc;
            if (lc == "n") begin
                nxt.phase = PH_NAN;
                nxt.word_match_index = 2'd1;
            end else if (is_sign) begin
                nxt.negative = is_minus;
                nxt.phase = PH_SIGNED;
            end
        end else begin
            // A missing sign falls through into the next phase with the same character.
            if (ph == PH_WS) begin
                ph = PH_SIGNED;
            end else if (ph == PH_EXPSIGN && !is_sign) begin
                ph = PH_EXPFIRST;
            end
            case (ph)
                PH_SIGNED: begin
                    if (lc == "i") begin
                        nxt.phase = PH_INF;
                        nxt.word_match_index = 2'd1;
                        nxt.position = pos_inc;
                    end else if (ch == "0") begin
                        nxt.phase = PH_ZERO;
                        nxt.position = pos_inc;
                    end else begin
                        nxt = finish(cur, 64'd0, ST_FORMAT, cur.position);
                    end
                end
                PH_NAN, PH_INF: begin
                    if (lc != want) begin
                        nxt = finish(cur, 64'd0, ST_FORMAT, word_start);
                    end else if (cur.word_match_index == 2'd1) begin
                        nxt.word_match_index = 2'd2;
                        nxt.position = pos_inc;
                    end else if (ph == PH_NAN) begin
                        nxt = finish(cur, NAN_BITS, ST_OK, pos_inc);
                    end else begin
                        nxt = finish(cur, INF_BITS | sign_mask, ST_OK, pos_inc);
                    end
                end
                PH_ZERO: begin
                    if (lc == "x") begin
                        nxt.phase = PH_FIRSTHEX;
                        nxt.position = pos_inc;
                    end else begin
                        nxt = finish(cur, 64'd0, ST_FORMAT, cur.position);
                    end
                end
                PH_FIRSTHEX, PH_INT: begin
                    if (is_hex) begin
                        if (cur.leading_found) begin
                            nxt = append_digit(cur, hval);
                            nxt.exponent_adjust = adj_add(cur.exponent_adjust, 4'sd4);
                        end else if (hval != 4'd0) begin
                            nxt = place_leading(cur, hval, 1'b0);
                        end
                        nxt.phase = PH_INT;
                        nxt.position = pos_inc;
                    end else if (ph == PH_INT && ch == ".") begin
                        nxt.phase = PH_FRAC;
                        nxt.position = pos_inc;
                    end else if (ph == PH_INT && lc == "p") begin
                        nxt.phase = PH_EXPSIGN;
                        nxt.position = pos_inc;
                    end else begin
                        nxt = finish(cur, 64'd0, ST_FORMAT, cur.position);
                    end
                end
                PH_FRAC: begin
                    if (is_hex) begin
                        if (cur.leading_found) begin
                            nxt = append_digit(cur, hval);
                        end else if (hval != 4'd0) begin
                            nxt = place_leading(cur, hval, 1'b1);
                        end else begin
                            nxt.exponent_adjust = adj_add(cur.exponent_adjust, -4'sd4);
                        end
                        nxt.position = pos_inc;
                    end else if (lc == "p") begin
                        nxt.phase = PH_EXPSIGN;
                        nxt.position = pos_inc;
                    end else begin
                        nxt = finish(cur, 64'd0, ST_FORMAT, cur.position);
                    end
                end
                PH_EXPSIGN: begin
                    nxt.exponent_negative = is_minus;
                    nxt.phase = PH_EXPFIRST;
                    nxt.position = pos_inc;
                end
                PH_EXPFIRST: begin
                    if (is_dec) begin
                        nxt.decimal_exponent = {16'b0, hval};
                        nxt.phase = PH_EXPDIG;
                        nxt.position = pos_inc;
                    end else begin
                        nxt = finish(cur, 64'd0, ST_FORMAT, cur.position);
                    end
                end
                PH_EXPDIG: begin
                    if (is_dec) begin
                        if (cur.decimal_exponent < DEC_LIMIT) begin
                            nxt.decimal_exponent = dec_times_ten;
                        end
                        nxt.position = pos_inc;
                    end else if (strict_end && ch != 8'd0) begin
                        nxt = finish(cur, 64'd0, ST_FORMAT, cur.position);
                    end else if (!cur.leading_found) begin
                        nxt = finish(cur, sign_mask, ST_OK, cur.position);
                    end else if (exp_sum[22] || exp_sum == 23'sd0) begin
                        nxt = finish(cur, sign_mask, ST_UNDERFLOW, cur.position);
                    end else if (exp_sum >= EXP_MAX) begin
                        nxt = finish(cur, sign_mask | INF_BITS, ST_OVERFLOW, cur.position);
                    end else begin
                        nxt = finish(cur, {cur.negative, exp_sum[10:0],
                                           cur.fraction_bits[63:12]},
                                     ST_OK, cur.position);
                    end
                end
                default: begin
                    // Text after the end of the literal is ignored until the last byte.
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hex_float_text_to_double.sv -----
// Top level: hexadecimal float text in, one byte per request, binary64 result out.
// Depends on hftd_pkg and hftd_step.
// A byte accepted into the input register is parsed into the parser state when it fires;
// a result is registered onto m_tdata when its last byte fires. Throughput: one byte per
// cycle through the combinational step logic, but a last byte waits while m_tdata is held.
// Reset (aresetn low, synchronous) empties both registers, clears the parser and
// strict_end.
`default_nettype none

module hex_float_text_to_double
    import hftd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic                   cfg_wr_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] char_byte
    input  wire logic                   s_tlast,   // last
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // value_bits, status, stop_offset, zeros
);

    logic                   strict_end_reg;
    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   in_last_reg;
    parse_state_t           state_reg;
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    parse_state_t           st_char;
    parse_state_t           st_end;
    logic                   out_free;
    logic                   fire;
    logic [OUT_TDATA_W-1:0] m_data_next;

    hftd_step u_step_char (
        .cur        (state_reg),
        .ch         (in_char_reg),
        .strict_end (strict_end_reg),
        .nxt        (st_char)
    );

    // On the last byte the text ends with an implied zero byte.
    hftd_step u_step_end (
        .cur        (st_char),
        .ch         (8'd0),
        .strict_end (strict_end_reg),
        .nxt        (st_end)
    );

    assign out_free    = !m_valid_reg || m_tready;
    assign fire        = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready    = !in_valid_reg || fire;
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;
    assign m_data_next = OUT_TDATA_W'({st_end.position, st_end.held_status,
                                       st_end.held_value});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_end_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            state_reg      <= state_clear();
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                strict_end_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                state_reg <= in_last_reg ? state_clear() : st_char;
            end
            if (fire && in_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire && in_last_reg) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire
